// File: rtl/dpfsm_pkg.sv
// Shared constants, item type and lane functions for the data-parallel automaton.
`default_nettype none

package dpfsm_pkg;

    localparam int STATE_COUNT   = 16;
    localparam int ALPHABET_SIZE = 256;
    localparam int LANES         = 16;
    localparam int NIB_W         = 4;
    localparam int VEC_W         = LANES * NIB_W;
    localparam int SYM_W         = 8;
    localparam int TABLE_DEPTH   = 1 << SYM_W;

    localparam int IQ_DEPTH = 4;
    localparam int IQ_AW    = $clog2(IQ_DEPTH);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    typedef struct packed {
        logic               is_data;
        logic               sym_ok;
        logic               last;
        logic [SYM_W-1:0]   sym;
        logic [VEC_W-1:0]   row;
    } item_t;

    function automatic logic [VEC_W-1:0] identity_vec();
        logic [VEC_W-1:0] v;
        v = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (k < STATE_COUNT)
            begin
                v[k*NIB_W +: NIB_W] = NIB_W'(k);
            end
        end
        return v;
    endfunction

    // Each lane follows its own current state through the row of the symbol.
    function automatic logic [VEC_W-1:0] step_vec(input logic [VEC_W-1:0] vec,
                                                  input logic [VEC_W-1:0] row);
        logic [VEC_W-1:0] nxt;
        logic [NIB_W-1:0] cur;
        nxt = '0;
        for (int k = 0; k < LANES; k++)
        begin
            cur = vec[k*NIB_W +: NIB_W];
            if (k < STATE_COUNT)
            begin
                nxt[k*NIB_W +: NIB_W] = row[int'(cur)*NIB_W +: NIB_W];
            end
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dpfsm_front.sv
// Front end: accepts transactions, classifies them and buffers them in a short queue.
`default_nettype none

module dpfsm_front
    import dpfsm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               command,
    input  wire logic [SYM_W-1:0]   row_symbol,
    input  wire logic [VEC_W-1:0]   row_next_states,
    input  wire logic [SYM_W-1:0]   data_byte,
    input  wire logic               last_byte,
    output logic                    item_valid,
    output item_t                   item,
    input  wire logic               take
);

    item_t              iq_mem_reg [IQ_DEPTH];
    logic [IQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IQ_AW:0]     count_reg, count_next;
    logic               accept;
    logic               do_take;
    item_t              new_item;

    assign full       = (count_reg == (IQ_AW+1)'(IQ_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = iq_mem_reg[rd_ptr_reg];
    assign accept     = push & ~full;
    assign do_take    = take & item_valid;

    always_comb
    begin
        new_item.is_data = (command == CMD_DATA);
        new_item.sym     = (command == CMD_DATA) ? data_byte : row_symbol;
        new_item.sym_ok  = ({1'b0, new_item.sym} < (SYM_W+1)'(ALPHABET_SIZE));
        new_item.last    = (command == CMD_DATA) & last_byte;
        new_item.row     = row_next_states;
    end

    always_comb
    begin
        wr_ptr_next = accept  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (IQ_AW+1)'(accept) - (IQ_AW+1)'(do_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            iq_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dpfsm_back.sv
// Back end: transition table memory, running state vector and result issue.
`default_nettype none

module dpfsm_back
    import dpfsm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire item_t              item,
    output logic                    take,
    input  wire logic [RQ_AW:0]     res_count,
    output logic                    res_push,
    output logic [VEC_W-1:0]        res_vec
);

    logic [VEC_W-1:0]   tbl_mem [TABLE_DEPTH];
    logic [VEC_W-1:0]   rd_row_reg;

    logic               s2_vld_reg;
    logic               s2_data_reg;
    logic               s2_ok_reg;
    logic               s2_last_reg;
    logic [VEC_W-1:0]   vec_reg, vec_next;
    logic [VEC_W-1:0]   stepped;
    logic               s2_res;
    logic [RQ_AW+1:0]   rq_used;

    // Reserve a result slot for a last data byte still in the second stage.
    assign s2_res  = s2_vld_reg & s2_data_reg & s2_last_reg;
    assign rq_used = {1'b0, res_count} + (RQ_AW+2)'(s2_res);
    assign take    = item_valid & (rq_used < (RQ_AW+2)'(RQ_DEPTH));

    // Table write and row read share one port; a write item never needs its read.
    always_ff @(posedge clk)
    begin
        if (take && !item.is_data && item.sym_ok)
        begin
            tbl_mem[item.sym] <= item.row;
        end
        rd_row_reg <= tbl_mem[item.sym];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_data_reg <= item.is_data;
        s2_ok_reg   <= item.sym_ok;
        s2_last_reg <= item.last;
    end

    always_comb
    begin
        stepped  = (s2_data_reg && s2_ok_reg) ? step_vec(vec_reg, rd_row_reg) : vec_reg;
        res_vec  = stepped;
        res_push = s2_res;
        vec_next = vec_reg;
        if (s2_vld_reg && s2_data_reg)
        begin
            vec_next = s2_last_reg ? identity_vec() : stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= identity_vec();
        end
        else
        begin
            vec_reg <= vec_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dpfsm_resq.sv
// Result queue: holds finished state vectors until they are popped.
`default_nettype none

module dpfsm_resq
    import dpfsm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_push,
    input  wire logic [VEC_W-1:0]   res_vec,
    output logic [RQ_AW:0]          res_count,
    input  wire logic               pop,
    output logic                    empty,
    output logic [VEC_W-1:0]        final_states
);

    logic [VEC_W-1:0]   rq_mem_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_AW:0]     count_reg, count_next;
    logic               do_pop;

    assign empty        = (count_reg == '0);
    assign res_count    = count_reg;
    assign final_states = rq_mem_reg[rd_ptr_reg];
    assign do_pop       = pop & ~empty;

    always_comb
    begin
        wr_ptr_next = res_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop   ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (RQ_AW+1)'(res_push) - (RQ_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            rq_mem_reg[wr_ptr_reg] <= res_vec;
        end
    end

endmodule

`default_nettype wire

// File: rtl/parallel_dfa_transition_composer_unit.sv
// Top level of the data-parallel 16-state byte automaton.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | push / full        | command, row_symbol, row_next_states,
//           |                    | data_byte, last_byte
//  result   | empty / pop        | final_states
//
// One transaction per cycle sustained while the result queue has room; the 256x64
// table read is registered and the 16-lane state update is combinational, so a last
// byte passes the input queue, the table read register and the lane update before
// it is written into the result queue.
// Reset clears both queues and returns the state vector to the identity; the
// table contents are undefined until written. A stalled result side backs up
// through the four-entry result queue into the four-entry input queue.
`default_nettype none

module parallel_dfa_transition_composer_unit
    import dpfsm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               command,
    input  wire logic [SYM_W-1:0]   row_symbol,
    input  wire logic [VEC_W-1:0]   row_next_states,
    input  wire logic [SYM_W-1:0]   data_byte,
    input  wire logic               last_byte,
    output logic                    empty,
    input  wire logic               pop,
    output logic [VEC_W-1:0]        final_states
);

    logic               item_valid;
    item_t              item;
    logic               take;
    logic [RQ_AW:0]     res_count;
    logic               res_push;
    logic [VEC_W-1:0]   res_vec;

    dpfsm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .row_symbol      (row_symbol),
        .row_next_states (row_next_states),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .item_valid      (item_valid),
        .item            (item),
        .take            (take)
    );

    dpfsm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_count  (res_count),
        .res_push   (res_push),
        .res_vec    (res_vec)
    );

    dpfsm_resq u_resq (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_push     (res_push),
        .res_vec      (res_vec),
        .res_count    (res_count),
        .pop          (pop),
        .empty        (empty),
        .final_states (final_states)
    );

endmodule

`default_nettype wire

// File: rtl/dpfsm_checker.sv
// Port-level checker for the automaton top level, with its bind statement.
`default_nettype none

module dpfsm_checker
    import dpfsm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic               command,
    input  wire logic               last_byte,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic [VEC_W-1:0]   final_states
);

    localparam int MAX_PEND = IQ_DEPTH + RQ_DEPTH + 1;
    localparam int PEND_W   = $clog2(MAX_PEND + 2);

    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic               last_in;
    logic               res_out;

    // Results owed: accepted last data bytes not yet popped.
    assign last_in = push & ~full & (command == CMD_DATA) & last_byte;
    assign res_out = pop & ~empty;

    always_comb
    begin
        pend_next = pend_reg + PEND_W'(last_in) - PEND_W'(res_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pend_reg != '0)
        else $error("result shown with no last data byte outstanding");

    a_pend_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(MAX_PEND))
        else $error("more results owed than the block can hold");

    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an accepted transaction");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(final_states))
        else $error("waiting result changed or vanished");

endmodule

bind parallel_dfa_transition_composer_unit dpfsm_checker u_dpfsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .command      (command),
    .last_byte    (last_byte),
    .empty        (empty),
    .pop          (pop),
    .final_states (final_states)
);

`default_nettype wire

// File: test/tb_parallel_dfa_transition_composer_unit.sv
// Testbench for the data-parallel 16-state automaton: directed and random checks.
`timescale 1ns / 1ps

module tb_parallel_dfa_transition_composer_unit;
    import dpfsm_pkg::*;

    localparam int ITEM_TARGET = 600;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 12;

    // receiver stall patterns
    localparam int RECV_STEADY = 0;
    localparam int RECV_RANDOM = 1;
    localparam int RECV_BURSTY = 2;

    localparam logic [VEC_W-1:0] ROW_ZERO    = 64'h0000_0000_0000_0000;
    localparam logic [VEC_W-1:0] ROW_ALL_TOP = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [VEC_W-1:0] ROW_SAME    = 64'hFEDC_BA98_7654_3210;
    localparam logic [VEC_W-1:0] ROW_PLUS1   = 64'h0FED_CBA9_8765_4321;
    localparam logic [VEC_W-1:0] ROW_MIRROR  = 64'h0123_4567_89AB_CDEF;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic               command;
    logic [SYM_W-1:0]   row_symbol;
    logic [VEC_W-1:0]   row_next_states;
    logic [SYM_W-1:0]   data_byte;
    logic               last_byte;
    logic               empty;
    logic               pop;
    logic [VEC_W-1:0]   final_states;

    // predictor state
    logic [VEC_W-1:0]   fsm_table [TABLE_DEPTH];
    bit                 row_known [TABLE_DEPTH];
    logic [SYM_W-1:0]   known_syms [$];
    logic [VEC_W-1:0]   lane_vec;
    logic [VEC_W-1:0]   expected_finals [$];

    int items_sent;
    int rows_written;
    int bytes_fed;
    int finals_checked;
    int error_count;
    int idle_cycles;
    int recv_mode;
    int pop_run_left;
    bit sender_bursty;
    int burst_left;

    parallel_dfa_transition_composer_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .row_symbol      (row_symbol),
        .row_next_states (row_next_states),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .empty           (empty),
        .pop             (pop),
        .final_states    (final_states)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [VEC_W-1:0] identity_lanes();
        logic [VEC_W-1:0] v;
        v = '0;
        for (int k = 0; k < STATE_COUNT; k++)
        begin
            v[k*NIB_W +: NIB_W] = NIB_W'(k);
        end
        return v;
    endfunction

    // lane k moves from its current state through the symbol's row
    function automatic logic [VEC_W-1:0] compose_lanes(input logic [VEC_W-1:0] cur_vec,
                                                       input logic [VEC_W-1:0] row);
        logic [VEC_W-1:0] nxt;
        logic [NIB_W-1:0] st;
        nxt = '0;
        for (int k = 0; k < STATE_COUNT; k++)
        begin
            st = cur_vec[k*NIB_W +: NIB_W];
            nxt[k*NIB_W +: NIB_W] = row[st*NIB_W +: NIB_W];
        end
        return nxt;
    endfunction

    function automatic logic [VEC_W-1:0] random_row();
        return {$urandom, $urandom};
    endfunction

    task automatic track_transaction(input logic cmd, input logic [SYM_W-1:0] sym,
                                     input logic [VEC_W-1:0] row,
                                     input logic [SYM_W-1:0] db, input logic lst);
        items_sent++;
        if (cmd == CMD_WRITE)
        begin
            fsm_table[sym] = row;
            if (!row_known[sym])
            begin
                row_known[sym] = 1'b1;
                known_syms.push_back(sym);
            end
            rows_written++;
        end
        else
        begin
            bytes_fed++;
            lane_vec = compose_lanes(lane_vec, fsm_table[db]);
            if (lst)
            begin
                expected_finals.push_back(lane_vec);
                lane_vec = identity_lanes();
            end
        end
    endtask

    task automatic send_item(input logic cmd, input logic [SYM_W-1:0] sym,
                             input logic [VEC_W-1:0] row,
                             input logic [SYM_W-1:0] db, input logic lst);
        int gap;
        if (sender_bursty && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        push            <= 1'b1;
        command         <= cmd;
        row_symbol      <= sym;
        row_next_states <= row;
        data_byte       <= db;
        last_byte       <= lst;
        do
            @(posedge clk);
        while (full);
        track_transaction(cmd, sym, row, db, lst);
    endtask

    // the unused fields carry random noise
    task automatic write_row(input logic [SYM_W-1:0] sym, input logic [VEC_W-1:0] row);
        send_item(CMD_WRITE, sym, row, SYM_W'($urandom), 1'($urandom));
    endtask

    task automatic feed_byte(input logic [SYM_W-1:0] db, input logic lst);
        send_item(CMD_DATA, SYM_W'($urandom), random_row(), db, lst);
    endtask

    function automatic logic [SYM_W-1:0] pick_known();
        return known_syms[$urandom_range(0, known_syms.size() - 1)];
    endfunction

    task automatic send_message(input int len, input bit allow_writes);
        for (int i = 0; i < len; i++)
        begin
            if (allow_writes && $urandom_range(0, 7) == 0)
                write_row(SYM_W'($urandom), random_row());
            feed_byte(pick_known(), i == len - 1);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        push <= 1'b0;
        while (expected_finals.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [VEC_W-1:0] exp_val,
                                 input logic [VEC_W-1:0] act_val);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s: expected %h, got %h", $realtime, what, exp_val, act_val);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_finals.size() == 0)
                note_mismatch("final_states with no transaction pending", 'x, final_states);
            else
            begin
                if (final_states !== expected_finals[0])
                    note_mismatch("final_states", expected_finals[0], final_states);
                void'(expected_finals.pop_front());
                finals_checked++;
            end
        end
    end

    always @(negedge clk)
    begin
        case (recv_mode)
            RECV_STEADY: pop <= 1'b1;
            RECV_RANDOM: pop <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (pop_run_left == 0)
                begin
                    pop <= !pop;
                    pop_run_left = $urandom_range(1, 12);
                end
                else
                begin
                    pop_run_left--;
                end
            end
        endcase
    end

    // watchdog: cycles without any transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("tb_parallel_dfa_transition_composer_unit: done, errors");
                $finish;
            end
        end
    end

    task automatic test_table_extremes();
        write_row(8'h00, ROW_ZERO);
        write_row(8'hFF, ROW_ALL_TOP);
        // a write ignores last_byte and data_byte
        send_item(CMD_WRITE, 8'h55, ROW_SAME, 8'hFF, 1'b1);
        write_row(8'hAA, ROW_PLUS1);
        write_row(8'h0F, ROW_MIRROR);
    endtask

    task automatic test_single_byte_messages();
        feed_byte(8'h00, 1'b1);
        feed_byte(8'hFF, 1'b1);
        feed_byte(8'h55, 1'b1);
        feed_byte(8'hAA, 1'b1);
        feed_byte(8'h0F, 1'b1);
    endtask

    task automatic test_multi_byte_messages();
        repeat (3) feed_byte(8'hAA, 1'b0);
        feed_byte(8'hAA, 1'b1);
        feed_byte(8'h0F, 1'b0);
        feed_byte(8'h0F, 1'b1);
        feed_byte(8'h55, 1'b0);
        feed_byte(8'h00, 1'b0);
        feed_byte(8'hAA, 1'b1);
    endtask

    // a row rewritten in the middle of a message takes effect on the next byte
    task automatic test_rewrite_mid_message();
        feed_byte(8'hAA, 1'b0);
        write_row(8'hAA, ROW_MIRROR);
        feed_byte(8'hAA, 1'b1);
        write_row(8'hAA, random_row());
    endtask

    task automatic test_drain_pause();
        sender_bursty = 1'b1;
        recv_mode = RECV_BURSTY;
        for (int i = 0; i < 4; i++)
            send_message($urandom_range(1, 5), 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int next_shuffle;
        next_shuffle = items_sent;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_shuffle)
            begin
                sender_bursty = ($urandom_range(0, 3) != 0);
                recv_mode = $urandom_range(RECV_STEADY, RECV_BURSTY);
                next_shuffle = items_sent + $urandom_range(20, 60);
            end
            if ($urandom_range(0, 9) < 2)
                write_row(SYM_W'($urandom), random_row());
            else
                send_message($urandom_range(1, 8), 1'b1);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        push            = 1'b0;
        command         = CMD_WRITE;
        row_symbol      = '0;
        row_next_states = '0;
        data_byte       = '0;
        last_byte       = 1'b0;
        pop             = 1'b0;
        items_sent      = 0;
        rows_written    = 0;
        bytes_fed       = 0;
        finals_checked  = 0;
        error_count     = 0;
        idle_cycles     = 0;
        pop_run_left    = 0;
        burst_left      = 0;
        sender_bursty   = 1'b0;
        recv_mode       = RECV_STEADY;
        lane_vec        = identity_lanes();
        foreach (row_known[i])
            row_known[i] = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_extremes();
        test_single_byte_messages();
        test_multi_byte_messages();
        test_rewrite_mid_message();
        test_drain_pause();
        test_random_traffic();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_finals.size() != 0)
        begin
            error_count += expected_finals.size();
            $display("%0d final_states never arrived", expected_finals.size());
        end

        $display("covered %0d transactions: %0d row writes, %0d data bytes",
                 items_sent, rows_written, bytes_fed);
        $display("checked %0d final state vectors, %0d mismatches",
                 finals_checked, error_count);
        if (error_count == 0)
            $display("tb_parallel_dfa_transition_composer_unit: done, clean");
        else
            $display("tb_parallel_dfa_transition_composer_unit: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dpfsm_pkg.sv
rtl/dpfsm_front.sv
rtl/dpfsm_back.sv
rtl/dpfsm_resq.sv
rtl/parallel_dfa_transition_composer_unit.sv
rtl/dpfsm_checker.sv
test/tb_parallel_dfa_transition_composer_unit.sv
